// ----- rtl/sorted_priority_queue_macros.svh -----
// Assertion macros for the sorted priority queue checker.
// Both macros expect a signal clk, and SPQ_ASSERT_IMPLY also rst, in scope.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SPQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked around reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// Package for the sorted priority queue: field widths, codes, word types.
// No dependencies; used by all files but spq_mem and the macro header.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int ACTION_W = 3;
  localparam int KEY_W    = 16;
  localparam int VALUE_W  = 16;
  localparam int POS_W    = 4;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_OFFER        = 3'd0,
    ACT_POLL         = 3'd1,
    ACT_PEEK         = 3'd2,
    ACT_READ_AT      = 3'd3,
    ACT_REMOVE_VALUE = 3'd4,
    ACT_REMOVE_AT    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_FRONT_RD,
    S_FRONT_GET,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FILT_RD,
    S_FILT_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [KEY_W-1:0]    out_key;
    logic [VALUE_W-1:0]  out_value;
    logic [POS_W-1:0]    insert_position;
    logic [CNT_W-1:0]    removed_count;
    logic [CNT_W-1:0]    count;
  } rsp_t;

endpackage

// ----- rtl/spq_req_if.sv -----
// Request channel of the sorted priority queue: valid, ready and one word.
// Depends on spq_pkg for the field widths.
`timescale 1ns / 1ps

interface spq_req_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::ACTION_W-1:0] action;
  logic [spq_pkg::KEY_W-1:0]    key;
  logic [spq_pkg::VALUE_W-1:0]  value;
  logic [spq_pkg::POS_W-1:0]    position;

  modport source (output valid, action, key, value, position, input ready);
  modport sink (input valid, action, key, value, position, output ready);
endinterface

// ----- rtl/spq_rsp_if.sv -----
// Response channel of the sorted priority queue: valid, ready and one word.
// Depends on spq_pkg for the field widths.
`timescale 1ns / 1ps

interface spq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::KEY_W-1:0]    out_key;
  logic [spq_pkg::VALUE_W-1:0]  out_value;
  logic [spq_pkg::POS_W-1:0]    insert_position;
  logic [spq_pkg::CNT_W-1:0]    removed_count;
  logic [spq_pkg::CNT_W-1:0]    count;

  modport source (output valid, status, out_key, out_value, insert_position,
                  removed_count, count, input ready);
  modport sink (input valid, status, out_key, out_value, insert_position,
                removed_count, count, output ready);
endinterface

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue: one word in, one response word out per request.
// Peek/read-at read one entry; refused offers and bad requests go straight
// to the response; an offer moves up entries with keys not smaller, then
// writes; poll/remove-at shift later entries down; remove-by-value compacts.
// The next request is taken the cycle after the response loads.
// Reset (synchronous, active high) empties the queue; entries need no clear.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(DEPTH);

  spq_pkg::req_t          req_word;
  spq_pkg::rsp_t          fin, out_word;
  logic                   fin_valid, fin_ready, out_valid;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0]   rd_key, wr_key;
  logic [VALUE_WIDTH-1:0] rd_value, wr_value;
  logic                   wr_en;

  always_comb begin
    req_word.action   = req.action;
    req_word.key      = req.key;
    req_word.value    = req.value;
    req_word.position = req.position;
  end

  spq_seq #(
    .DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_seq (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready), .req(req_word),
    .fin_valid(fin_valid), .fin_ready(fin_ready), .fin(fin),
    .rd_addr(rd_addr), .rd_key(rd_key), .rd_value(rd_value),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key), .wr_value(wr_value)
  );

  spq_mem #(
    .DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mem (
    .clk(clk),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key), .wr_value(wr_value),
    .rd_addr(rd_addr), .rd_key(rd_key), .rd_value(rd_value)
  );

  // The response register frees the sequencer while a word waits downstream.
  assign fin_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_valid && fin_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      out_word <= fin;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_word.status;
  assign rsp.out_key         = out_word.out_key;
  assign rsp.out_value       = out_word.out_value;
  assign rsp.insert_position = out_word.insert_position;
  assign rsp.removed_count   = out_word.removed_count;
  assign rsp.count           = out_word.count;

endmodule

// ----- rtl/spq_mem.sv -----
// Entry storage of the sorted priority queue: key and value arrays with one
// write port and one read port whose data is registered. No dependencies.
`timescale 1ns / 1ps

module spq_mem #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [KEY_WIDTH-1:0]       wr_key,
  input  logic [VALUE_WIDTH-1:0]     wr_value,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [KEY_WIDTH-1:0]       rd_key,
  output logic [VALUE_WIDTH-1:0]     rd_value
);

  logic [KEY_WIDTH-1:0]   keys   [DEPTH];
  logic [VALUE_WIDTH-1:0] values [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_addr]   <= wr_key;
      values[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_key   <= keys[rd_addr];
    rd_value <= values[rd_addr];
  end

endmodule

// ----- rtl/spq_seq.sv -----
// Sequencer of the sorted priority queue: walks the entry memory one entry
// per read/write pair to insert, delete and compact. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_seq #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  spq_pkg::req_t              req,
  output logic                       fin_valid,
  input  logic                       fin_ready,
  output spq_pkg::rsp_t              fin,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic [KEY_WIDTH-1:0]       rd_key,
  input  logic [VALUE_WIDTH-1:0]     rd_value,
  output logic                       wr_en,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic [KEY_WIDTH-1:0]       wr_key,
  output logic [VALUE_WIDTH-1:0]     wr_value
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_XW = (CNT_W > spq_pkg::POS_W) ? CNT_W : spq_pkg::POS_W;
  localparam int CNT_XW = (CNT_W > spq_pkg::CNT_W) ? CNT_W : spq_pkg::CNT_W;
  localparam int KEY_XW = (KEY_WIDTH > spq_pkg::KEY_W) ? KEY_WIDTH : spq_pkg::KEY_W;
  localparam int VAL_XW = (VALUE_WIDTH > spq_pkg::VALUE_W) ? VALUE_WIDTH
                                                           : spq_pkg::VALUE_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  spq_pkg::state_t  state, state_next;
  spq_pkg::status_t res_status;

  logic                   del;
  logic [KEY_WIDTH-1:0]   op_key, res_key;
  logic [VALUE_WIDTH-1:0] op_value, res_value;
  logic [CNT_W-1:0]       count, idx, wr_ptr, rcount, ipos;

  logic                   accept;
  logic [KEY_XW-1:0]      key_x, res_key_x;
  logic [VAL_XW-1:0]      value_x, res_value_x;
  logic [POS_XW-1:0]      pos_x, count_px, ipos_x;
  logic [CNT_XW-1:0]      count_x, rcount_x;
  logic                   pos_ok, front_ok, full;
  logic [CNT_W-1:0]       idx_dec, idx_inc, idx_inc2;
  logic                   shift_more, value_hit, move_more;

  assign accept    = req_valid && req_ready;
  assign key_x     = KEY_XW'(req.key);
  assign value_x   = VAL_XW'(req.value);
  assign pos_x     = POS_XW'(req.position);
  assign count_px  = POS_XW'(count);
  assign pos_ok    = pos_x < count_px;
  assign front_ok  = count != '0;
  assign full      = count == FULL_COUNT;
  assign idx_dec   = idx - 1'b1;
  assign idx_inc   = idx + 1'b1;
  assign idx_inc2  = idx_inc + 1'b1;
  // Entries at or above the insert point have keys that are not smaller.
  assign shift_more = rd_key >= op_key;
  assign value_hit  = rd_value == op_value;
  assign move_more  = idx_inc2 < count;

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          case (req.action)
            spq_pkg::ACT_OFFER: begin
              if (full) state_next = spq_pkg::S_FINISH;
              else if (!front_ok) state_next = spq_pkg::S_INS_PUT;
              else state_next = spq_pkg::S_INS_RD;
            end
            spq_pkg::ACT_POLL, spq_pkg::ACT_PEEK: begin
              state_next = front_ok ? spq_pkg::S_FRONT_RD : spq_pkg::S_FINISH;
            end
            spq_pkg::ACT_READ_AT, spq_pkg::ACT_REMOVE_AT: begin
              state_next = pos_ok ? spq_pkg::S_FRONT_RD : spq_pkg::S_FINISH;
            end
            spq_pkg::ACT_REMOVE_VALUE: begin
              state_next = front_ok ? spq_pkg::S_FILT_RD : spq_pkg::S_FINISH;
            end
            default: state_next = spq_pkg::S_FINISH;
          endcase
        end
      end
      spq_pkg::S_INS_RD: state_next = spq_pkg::S_INS_CMP;
      spq_pkg::S_INS_CMP: begin
        if (shift_more && idx_dec != '0) state_next = spq_pkg::S_INS_RD;
        else state_next = spq_pkg::S_INS_PUT;
      end
      spq_pkg::S_INS_PUT: state_next = spq_pkg::S_FINISH;
      spq_pkg::S_FRONT_RD: state_next = spq_pkg::S_FRONT_GET;
      spq_pkg::S_FRONT_GET: begin
        if (del && idx_inc < count) state_next = spq_pkg::S_SHIFT_RD;
        else state_next = spq_pkg::S_FINISH;
      end
      spq_pkg::S_SHIFT_RD: state_next = spq_pkg::S_SHIFT_WR;
      spq_pkg::S_SHIFT_WR: begin
        state_next = move_more ? spq_pkg::S_SHIFT_RD : spq_pkg::S_FINISH;
      end
      spq_pkg::S_FILT_RD: state_next = spq_pkg::S_FILT_CHK;
      spq_pkg::S_FILT_CHK: begin
        state_next = (idx_inc == count) ? spq_pkg::S_FINISH : spq_pkg::S_FILT_RD;
      end
      spq_pkg::S_FINISH: begin
        if (fin_ready) state_next = spq_pkg::S_IDLE;
      end
      default: state_next = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = state == spq_pkg::S_IDLE;
    fin_valid = state == spq_pkg::S_FINISH;
    wr_en     = 1'b0;
    wr_addr   = idx[IDX_W-1:0];
    wr_key    = rd_key;
    wr_value  = rd_value;
    rd_addr   = idx[IDX_W-1:0];
    case (state)
      spq_pkg::S_INS_RD: rd_addr = idx_dec[IDX_W-1:0];
      spq_pkg::S_INS_CMP: wr_en = shift_more;
      spq_pkg::S_INS_PUT: begin
        wr_en    = 1'b1;
        wr_key   = op_key;
        wr_value = op_value;
      end
      spq_pkg::S_SHIFT_RD: rd_addr = idx_inc[IDX_W-1:0];
      spq_pkg::S_SHIFT_WR: wr_en = 1'b1;
      spq_pkg::S_FILT_CHK: begin
        wr_en   = !value_hit;
        wr_addr = wr_ptr[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        spq_pkg::S_IDLE: begin
          if (accept) begin
            op_key     <= key_x[KEY_WIDTH-1:0];
            op_value   <= value_x[VALUE_WIDTH-1:0];
            del        <= (req.action == spq_pkg::ACT_POLL) ||
                          (req.action == spq_pkg::ACT_REMOVE_AT);
            res_status <= spq_pkg::ST_OK;
            res_key    <= '0;
            res_value  <= '0;
            ipos       <= '0;
            rcount     <= '0;
            wr_ptr     <= '0;
            idx        <= '0;
            case (req.action)
              spq_pkg::ACT_OFFER: begin
                idx <= count;
                if (full) res_status <= spq_pkg::ST_FULL;
              end
              spq_pkg::ACT_POLL, spq_pkg::ACT_PEEK: begin
                if (!front_ok) res_status <= spq_pkg::ST_EMPTY;
              end
              spq_pkg::ACT_READ_AT, spq_pkg::ACT_REMOVE_AT: begin
                idx <= pos_x[CNT_W-1:0];
                if (!pos_ok) res_status <= spq_pkg::ST_EMPTY;
              end
              default: ;
            endcase
          end
        end
        spq_pkg::S_INS_CMP: begin
          if (shift_more) idx <= idx_dec;
        end
        spq_pkg::S_INS_PUT: begin
          ipos  <= idx;
          count <= count + 1'b1;
        end
        spq_pkg::S_FRONT_GET: begin
          res_key   <= rd_key;
          res_value <= rd_value;
          if (del && !(idx_inc < count)) count <= count - 1'b1;
        end
        spq_pkg::S_SHIFT_WR: begin
          idx <= idx_inc;
          if (!move_more) count <= count - 1'b1;
        end
        spq_pkg::S_FILT_CHK: begin
          idx <= idx_inc;
          if (value_hit) rcount <= rcount + 1'b1;
          else wr_ptr <= wr_ptr + 1'b1;
          // The kept entries are compacted to the front, so the write
          // pointer becomes the new count once the last entry is checked.
          if (idx_inc == count) count <= value_hit ? wr_ptr : wr_ptr + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign res_key_x   = KEY_XW'(res_key);
  assign res_value_x = VAL_XW'(res_value);
  assign ipos_x      = POS_XW'(ipos);
  assign count_x     = CNT_XW'(count);
  assign rcount_x    = CNT_XW'(rcount);

  always_comb begin
    fin.status          = res_status;
    fin.out_key         = res_key_x[spq_pkg::KEY_W-1:0];
    fin.out_value       = res_value_x[spq_pkg::VALUE_W-1:0];
    fin.insert_position = ipos_x[spq_pkg::POS_W-1:0];
    fin.removed_count   = rcount_x[spq_pkg::CNT_W-1:0];
    fin.count           = count_x[spq_pkg::CNT_W-1:0];
  end

endmodule

// ----- rtl/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_macros.svh.
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_checker #(
  parameter int DEPTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic [spq_pkg::STATUS_W-1:0] status,
  input logic [spq_pkg::KEY_W-1:0]    out_key,
  input logic [spq_pkg::VALUE_W-1:0]  out_value,
  input logic [spq_pkg::POS_W-1:0]    insert_position,
  input logic [spq_pkg::CNT_W-1:0]    removed_count,
  input logic [spq_pkg::CNT_W-1:0]    count
);

  localparam int CW = spq_pkg::CNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // A refused offer leaves a full queue and returns no entry.
  `SPQ_ASSERT_IMPLY(a_full_word, rsp_valid && status == spq_pkg::ST_FULL, count == FULL_CNT && insert_position == '0 && out_key == '0 && out_value == '0, "full response carries data or wrong count")

  // An empty or bad-position response returns no entry and removes nothing.
  `SPQ_ASSERT_IMPLY(a_empty_word, rsp_valid && status == spq_pkg::ST_EMPTY, out_key == '0 && out_value == '0 && removed_count == '0, "empty response carries data")

  `SPQ_ASSERT_IMPLY(a_status_code, rsp_valid, status == spq_pkg::ST_OK || status == spq_pkg::ST_EMPTY || status == spq_pkg::ST_FULL, "undefined status code")

  `SPQ_ASSERT_NEXT(a_reset_quiet, rst, !rsp_valid, "response valid right after reset")

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp.valid),
  .status(rsp.status),
  .out_key(rsp.out_key),
  .out_value(rsp.out_value),
  .insert_position(rsp.insert_position),
  .removed_count(rsp.removed_count),
  .count(rsp.count)
);
